### rtl/dvl_pkg.sv
// Shared constants, types and microprogram builder for the packet deframer.
// Depends on nothing; every other file of the block but dvl_ifs imports this package.
package dvl_pkg;

  localparam int PKT_LEN      = 116;
  localparam int SUM_END      = 114;
  localparam int START_LEN    = 6;
  localparam int ID_LEN       = 9;
  localparam int SYS_TYPE_POS = 15;
  localparam int NUM_FIELDS   = 23;
  localparam int VX_POS       = 30;
  localparam int VY_POS       = 34;
  localparam int VZ_POS       = 38;

  localparam int AW = $clog2(PKT_LEN);
  localparam int MW = $clog2(START_LEN);
  localparam int FW = $clog2(NUM_FIELDS);

  localparam logic [7:0] SYS_TYPE_VAL = 8'h4C;

  // Result codes.
  localparam logic [2:0] RC_OK      = 3'd0;
  localparam logic [2:0] RC_BAD_ID  = 3'd1;
  localparam logic [2:0] RC_BAD_SYS = 3'd2;
  localparam logic [2:0] RC_BAD_SUM = 3'd3;
  localparam logic [2:0] RC_BAD_VEL = 3'd4;

  // Microcode sequencing operations.
  localparam logic [1:0] OP_NOP = 2'd0;
  localparam logic [1:0] OP_JOK = 2'd1;
  localparam logic [1:0] OP_END = 2'd2;

  typedef struct packed {
    logic ok;
    logic [2:0] code;
  } dvl_status_t;

  function automatic logic [7:0] start_byte(input logic [MW-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'hAA;
      3'd1:    b = 8'h10;
      3'd2:    b = 8'h01;
      3'd3:    b = 8'h74;
      3'd4:    b = 8'h00;
      3'd5:    b = 8'h10;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] id_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h05;
      4'd1:    b = 8'h6D;
      4'd2:    b = 8'h00;
      4'd3:    b = 8'hAA;
      4'd4:    b = 8'h11;
      4'd5:    b = 8'h69;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [AW-1:0] field_pos(input logic [FW-1:0] f);
    logic [AW-1:0] p;
    unique case (f)
      5'd0:    p = 7'd29;
      5'd1:    p = 7'd21;
      5'd2:    p = 7'd22;
      5'd3:    p = 7'd23;
      5'd4:    p = 7'd24;
      5'd5:    p = 7'd25;
      5'd6:    p = 7'd26;
      5'd7:    p = 7'd27;
      5'd8:    p = 7'(VX_POS);
      5'd9:    p = 7'(VY_POS);
      5'd10:   p = 7'(VZ_POS);
      5'd11:   p = 7'd42;
      5'd12:   p = 7'd46;
      5'd13:   p = 7'd50;
      5'd14:   p = 7'd54;
      5'd15:   p = 7'd58;
      5'd16:   p = 7'd62;
      5'd17:   p = 7'd66;
      5'd18:   p = 7'd70;
      5'd19:   p = 7'd72;
      5'd20:   p = 7'd74;
      5'd21:   p = 7'd78;
      5'd22:   p = 7'd82;
      default: p = 7'd0;
    endcase
    return p;
  endfunction

  function automatic int field_size(input logic [FW-1:0] f);
    int n;
    if (f < 5'd7) begin
      n = 1;
    end else if (f == 5'd7 || f == 5'd18 || f == 5'd19) begin
      n = 2;
    end else begin
      n = 4;
    end
    return n;
  endfunction

  function automatic logic [15:0] start_sum();
    logic [15:0] s;
    s = '0;
    for (int i = 0; i < START_LEN; i++) begin
      s = s + {8'h00, start_byte(MW'(i))};
    end
    return s;
  endfunction

  localparam logic [15:0] START_SUM = start_sum();

  // One control word per microprogram step.
  typedef struct packed {
    logic [1:0]    op;
    logic [6:0]    target;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [1:0]    lane;
    logic          clr;
    logic          emit;
    logic          emit_err;
    logic [FW-1:0] fidx;
    logic          last;
  } ctrl_t;

  localparam int UC_W = $bits(ctrl_t);

  function automatic int total_bytes();
    int n;
    n = 0;
    for (int f = 0; f < NUM_FIELDS; f++) begin
      n = n + field_size(FW'(f));
    end
    return n;
  endfunction

  // Check step, error step, one read step per field byte, final emit step.
  localparam int UC_DEPTH = 3 + total_bytes();
  localparam int SW = $clog2(UC_DEPTH);

  // Program: step 0 jumps over the error step when the packet is good.
  // Each field's first read carries the emit of the previous field.
  function automatic logic [UC_DEPTH*UC_W-1:0] build_ucode();
    logic [UC_DEPTH*UC_W-1:0] rom;
    ctrl_t w;
    int s;
    rom = '0;
    s = 0;
    w = '0;
    w.op = OP_JOK;
    w.target = 7'd2;
    rom[s*UC_W +: UC_W] = w;
    s++;
    w = '0;
    w.op = OP_END;
    w.emit = 1'b1;
    w.emit_err = 1'b1;
    w.last = 1'b1;
    rom[s*UC_W +: UC_W] = w;
    s++;
    for (int f = 0; f < NUM_FIELDS; f++) begin
      for (int k = 0; k < field_size(FW'(f)); k++) begin
        w = '0;
        w.op = OP_NOP;
        w.rd_en = 1'b1;
        w.rd_addr = field_pos(FW'(f)) + AW'(k);
        w.lane = 2'(k);
        w.clr = (k == 0);
        if (k == 0 && f > 0) begin
          w.emit = 1'b1;
          w.fidx = FW'(f - 1);
        end
        rom[s*UC_W +: UC_W] = w;
        s++;
      end
    end
    w = '0;
    w.op = OP_END;
    w.emit = 1'b1;
    w.fidx = FW'(NUM_FIELDS - 1);
    w.last = 1'b1;
    rom[s*UC_W +: UC_W] = w;
    return rom;
  endfunction

endpackage

### rtl/dvl_ifs.sv
// Valid/ready channel interfaces: received bytes in, field records out.
// Depends on nothing.
interface dvl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dvl_rec_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_code;
  logic [4:0]  field_index;
  logic [31:0] field_value;
  logic        last_record;

  modport source (output valid, output result_code, output field_index,
                  output field_value, output last_record, input ready);
  modport sink   (input valid, input result_code, input field_index,
                  input field_value, input last_record, output ready);
endinterface

### rtl/dvl_store.sv
// Packet byte memory: one write port, one registered read port.
// Depends on dvl_pkg.
module dvl_store
  import dvl_pkg::*;
(
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [PKT_LEN];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/dvl_frame.sv
// Start-pattern hunt, byte collection and on-the-fly packet checks.
// Depends on dvl_pkg.
module dvl_frame
  import dvl_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [7:0]    rx_byte,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic          start,
  output dvl_status_t   status
);

  logic          collecting_r, collecting_nxt;
  logic [MW-1:0] match_r, match_nxt;
  logic [AW-1:0] count_r, count_nxt;
  logic          pkt_open;

  logic [15:0] sum_r;
  logic [15:0] chk_r;
  logic        id_bad_r;
  logic        sys_bad_r;
  logic        exp_lsb_r;
  logic        vel_bad_r;

  assign pkt_open = in_fire && !collecting_r && (rx_byte == start_byte(match_r))
                    && (match_r == MW'(START_LEN - 1));

  always_comb begin
    collecting_nxt = collecting_r;
    match_nxt      = match_r;
    count_nxt      = count_r;
    start          = 1'b0;
    if (in_fire) begin
      if (!collecting_r) begin
        if (rx_byte == start_byte(match_r)) begin
          if (match_r == MW'(START_LEN - 1)) begin
            collecting_nxt = 1'b1;
            match_nxt      = '0;
            count_nxt      = AW'(START_LEN);
          end else begin
            match_nxt = match_r + MW'(1);
          end
        end else if (rx_byte == start_byte(MW'(0))) begin
          match_nxt = MW'(1);
        end else begin
          match_nxt = '0;
        end
      end else begin
        if (count_r == AW'(PKT_LEN - 1)) begin
          collecting_nxt = 1'b0;
          count_nxt      = '0;
          start          = 1'b1;
        end else begin
          count_nxt = count_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      match_r      <= '0;
      count_r      <= '0;
    end else begin
      collecting_r <= collecting_nxt;
      match_r      <= match_nxt;
      count_r      <= count_nxt;
    end
  end

  // The start bytes are never read back, so only body bytes go to the store;
  // their contribution to the sum is a constant.
  always_ff @(posedge clk) begin
    if (pkt_open) begin
      sum_r     <= START_SUM;
      id_bad_r  <= 1'b0;
      sys_bad_r <= 1'b0;
      vel_bad_r <= 1'b0;
    end else if (in_fire && collecting_r) begin
      if (count_r < AW'(SUM_END)) begin
        sum_r <= sum_r + {8'h00, rx_byte};
      end
      if (count_r == AW'(SUM_END)) begin
        chk_r[7:0] <= rx_byte;
      end
      if (count_r == AW'(SUM_END + 1)) begin
        chk_r[15:8] <= rx_byte;
      end
      if (count_r < AW'(START_LEN + ID_LEN)
          && rx_byte != id_byte(4'(count_r - AW'(START_LEN)))) begin
        id_bad_r <= 1'b1;
      end
      if (count_r == AW'(SYS_TYPE_POS) && rx_byte != SYS_TYPE_VAL) begin
        sys_bad_r <= 1'b1;
      end
      // Exponent of a float32 spans bit 7 of byte 2 and bits 6:0 of byte 3.
      if (count_r == AW'(VX_POS + 2) || count_r == AW'(VY_POS + 2)
          || count_r == AW'(VZ_POS + 2)) begin
        exp_lsb_r <= rx_byte[7];
      end
      if ((count_r == AW'(VX_POS + 3) || count_r == AW'(VY_POS + 3)
           || count_r == AW'(VZ_POS + 3)) && exp_lsb_r && (rx_byte[6:0] == 7'h7F)) begin
        vel_bad_r <= 1'b1;
      end
    end
  end

  always_comb begin
    priority if (id_bad_r) begin
      status.code = RC_BAD_ID;
    end else if (sys_bad_r) begin
      status.code = RC_BAD_SYS;
    end else if (sum_r != chk_r) begin
      status.code = RC_BAD_SUM;
    end else if (vel_bad_r) begin
      status.code = RC_BAD_VEL;
    end else begin
      status.code = RC_OK;
    end
    status.ok = (status.code == RC_OK);
  end

  assign wr_en   = in_fire && collecting_r;
  assign wr_addr = count_r;

endmodule

### rtl/dvl_useq.sv
// Microcoded readout sequencer: step counter, program ROM, conditional jump.
// Depends on dvl_pkg.
module dvl_useq
  import dvl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  status_ok,
  input  logic  adv,
  output logic  busy,
  output ctrl_t ctrl
);

  localparam logic [UC_DEPTH*UC_W-1:0] UCODE = build_ucode();

  logic          busy_r, busy_nxt;
  logic [SW-1:0] step_r, step_nxt;

  assign ctrl = ctrl_t'(UCODE[step_r*UC_W +: UC_W]);
  assign busy = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        step_nxt = '0;
      end
    end else if (adv) begin
      unique case (ctrl.op)
        OP_NOP: step_nxt = step_r + SW'(1);
        OP_JOK: step_nxt = status_ok ? SW'(ctrl.target) : step_r + SW'(1);
        OP_END: busy_nxt = 1'b0;
        default: step_nxt = step_r + SW'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

### rtl/dvl_binary_packet_deframer.sv
// Top level of the byte-serial packet deframer: framing, store, sequencer, output.
// Depends on dvl_pkg, dvl_ifs, dvl_frame, dvl_store and dvl_useq.
//
//   channel   dir  handshake       payload
//   in_ch     in   valid / ready   rx_byte[7:0]
//   out_ch    out  valid / ready   result_code[2:0], field_index[4:0],
//                                  field_value[31:0], last_record
//
// Cycles: one byte is taken per cycle while a packet is hunted or collected.
// After the 116th byte the input is held off while the microprogram runs: a
// failed packet takes 2 steps, a good one 67 steps, 65 of which each read one
// byte from the packet store; a stalled output holds the run longer.
// Reset is synchronous and active low; it clears the hunt and the sequencer,
// not the packet store. A stalled output holds its item and freezes the
// sequencer on its next emit step; the input side is not affected otherwise.
module dvl_binary_packet_deframer
  import dvl_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  dvl_byte_if.sink  in_ch,
  dvl_rec_if.source out_ch
);

  logic          in_fire;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          start;
  dvl_status_t   status;
  logic          busy;
  ctrl_t         ctrl;
  logic          adv;
  logic          rd_fire;
  logic          emit_fire;
  logic [7:0]    rdata;

  // The capture stage acts in the cycle after each store read.
  logic        cap_en_r;
  logic [1:0]  cap_lane_r;
  logic        cap_clr_r;
  logic [31:0] word_r, word_nxt, word_base;

  logic        out_valid_r;
  logic [2:0]  out_code_r;
  logic [4:0]  out_fidx_r;
  logic [31:0] out_value_r;
  logic        out_last_r;

  // Input is taken only while no record run is in progress.
  assign in_ch.ready = !busy;
  assign in_fire     = in_ch.valid && !busy;

  dvl_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .rx_byte (in_ch.rx_byte),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .start   (start),
    .status  (status)
  );

  // An emit step waits while the output register holds an item the sink is not ready to take.
  assign adv       = !ctrl.emit || !out_valid_r || out_ch.ready;
  assign rd_fire   = busy && adv && ctrl.rd_en;
  assign emit_fire = busy && adv && ctrl.emit;

  dvl_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status_ok (status.ok),
    .adv       (adv),
    .busy      (busy),
    .ctrl      (ctrl)
  );

  dvl_store u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_ch.rx_byte),
    .re    (rd_fire),
    .raddr (ctrl.rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_en_r <= 1'b0;
    end else begin
      cap_en_r <= rd_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_fire) begin
      cap_lane_r <= ctrl.lane;
      cap_clr_r  <= ctrl.clr;
    end
  end

  // Little-endian assembly: each read byte lands in its lane, the first byte
  // of a field clears the rest. The emit step sees the assembled word in the
  // same cycle as the field's last byte arrives.
  always_comb begin
    word_base = cap_clr_r ? 32'h0 : word_r;
    word_nxt  = word_r;
    if (cap_en_r) begin
      word_nxt = word_base;
      unique case (cap_lane_r)
        2'd0: word_nxt[7:0]   = rdata;
        2'd1: word_nxt[15:8]  = rdata;
        2'd2: word_nxt[23:16] = rdata;
        2'd3: word_nxt[31:24] = rdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_code_r  <= ctrl.emit_err ? status.code : RC_OK;
      out_fidx_r  <= ctrl.emit_err ? 5'd0 : ctrl.fidx;
      out_value_r <= ctrl.emit_err ? 32'h0 : word_nxt;
      out_last_r  <= ctrl.last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_code = out_code_r;
  assign out_ch.field_index = out_fidx_r;
  assign out_ch.field_value = out_value_r;
  assign out_ch.last_record = out_last_r;

endmodule

### rtl/dvl_chk.sv
// Port-level checker for the packet deframer, bound to the top level.
// Depends on dvl_pkg and dvl_binary_packet_deframer.
module dvl_chk
  import dvl_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  result_code,
  input logic [4:0]  field_index,
  input logic [31:0] field_value,
  input logic        last_record
);

  // A stalled record holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(field_value)
      && $stable(field_index) && $stable(result_code) && $stable(last_record))
    else $error("stalled record changed");

  // An error record is a lone, empty record.
  a_err_rec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_code != RC_OK |->
      last_record && field_index == 5'd0 && field_value == 32'h0)
    else $error("malformed error record");

  // A good run ends exactly on the last field.
  a_ok_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_code == RC_OK |->
      last_record == (field_index == 5'(NUM_FIELDS - 1)))
    else $error("last flag does not match final field");

  // No byte is taken while a run of records is still incomplete.
  a_no_rx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_record |-> !in_ready)
    else $error("input accepted during record run");

  // Codes stay within the defined set.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> result_code == RC_OK || result_code == RC_BAD_ID
      || result_code == RC_BAD_SYS || result_code == RC_BAD_SUM
      || result_code == RC_BAD_VEL)
    else $error("undefined result code");

endmodule

bind dvl_binary_packet_deframer dvl_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .result_code (out_ch.result_code),
  .field_index (out_ch.field_index),
  .field_value (out_ch.field_value),
  .last_record (out_ch.last_record)
);

### tb/tb_dvl_binary_packet_deframer.sv
// Self-checking testbench for dvl_binary_packet_deframer: framed bytes in, records out.
// Depends on dvl_pkg, dvl_ifs (dvl_byte_if, dvl_rec_if) and dvl_binary_packet_deframer.
module tb_dvl_binary_packet_deframer
  import dvl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Run limits. The cycle limit leaves a wide margin over the slowest legal run.
  // The drain covers the 67-step burst after a packet.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_LIMIT  = 40000;
  localparam int DRAIN_CYCLES  = 150;
  localparam int LONG_STALL    = 400;
  localparam int MAX_PRINTS    = 40;

  // Start pattern and data ID, first byte in the most significant position.
  localparam logic [47:0] SOP_BYTES     = 48'hAA_10_01_74_00_10;
  localparam logic [71:0] DATA_ID_BYTES = 72'h05_6D_00_AA_11_69_00_00_00;

  typedef struct packed {
    logic [2:0]  code;
    logic [4:0]  idx;
    logic [31:0] value;
    logic        last;
  } field_rec_t;

  typedef enum logic { DF_HUNT, DF_COLLECT } deframe_state_t;

  typedef enum int {
    PK_GOOD, PK_BAD_ID, PK_BAD_SYS, PK_BAD_SUM, PK_BAD_VX, PK_BAD_VY, PK_BAD_VZ
  } pkt_kind_t;

  typedef enum int { FILL_RANDOM, FILL_ZERO, FILL_ONES } fill_t;

  logic clk;
  logic rst_n;

  dvl_byte_if byte_ch ();
  dvl_rec_if  rec_ch ();

  dvl_binary_packet_deframer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_ch),
    .out_ch (rec_ch)
  );

  // Stimulus bookkeeping. Bytes waiting to be driven sit in rx_byte_queue; the
  // records that the accepted bytes must produce sit in expected_fields.
  logic [7:0] rx_byte_queue [$];
  field_rec_t expected_fields [$];
  int         bytes_pushed;
  int         bytes_accepted;
  int         recs_checked;
  int         err_count;
  int         cycle_count;
  int         pkts_good;
  int         pkts_bad;
  int         send_idle_pct;
  int         recv_idle_pct;
  logic       byte_taken;
  logic       hold_go;
  int         stall_left;

  // Predictor state: its own copy of the packet image and the framing counters.
  logic [7:0]     pkt_img [0:PKT_LEN-1];
  deframe_state_t df_state;
  logic [2:0]     match_cnt;
  logic [6:0]     fill_cnt;

  always #4 clk = ~clk;

  // Byte offset of each field inside the packet.
  function automatic int field_offset(input int f);
    int p;
    case (f)
      0:       p = 29;
      1, 2, 3, 4, 5, 6, 7: p = 20 + f;
      8, 9, 10, 11, 12, 13, 14, 15, 16, 17: p = 30 + 4 * (f - 8);
      18:      p = 70;
      19:      p = 72;
      default: p = 74 + 4 * (f - 20);
    endcase
    return p;
  endfunction

  // Width in bytes of each field.
  function automatic int field_bytes(input int f);
    int n;
    if (f <= 6) begin
      n = 1;
    end else if (f == 7 || f == 18 || f == 19) begin
      n = 2;
    end else begin
      n = 4;
    end
    return n;
  endfunction

  // Little-endian read of up to four bytes from the predicted packet image.
  function automatic logic [31:0] le_read(input int pos, input int n);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < n; k++) begin
      v[8*k +: 8] = pkt_img[pos + k];
    end
    return v;
  endfunction

  // Validation in the block's order; the first failing check decides the code.
  function automatic logic [2:0] packet_verdict();
    logic [15:0] sum;
    logic [31:0] vel;
    for (int i = 0; i < ID_LEN; i++) begin
      if (pkt_img[START_LEN + i] != DATA_ID_BYTES[8*(ID_LEN-1-i) +: 8]) begin
        return RC_BAD_ID;
      end
    end
    if (pkt_img[SYS_TYPE_POS] != SYS_TYPE_VAL) begin
      return RC_BAD_SYS;
    end
    sum = '0;
    for (int i = 0; i < SUM_END; i++) begin
      sum = sum + {8'h00, pkt_img[i]};
    end
    if (sum != {pkt_img[SUM_END+1], pkt_img[SUM_END]}) begin
      return RC_BAD_SUM;
    end
    // vx, vy and vz are fields 8 to 10; an all-ones exponent means inf or NaN.
    for (int f = 8; f <= 10; f++) begin
      vel = le_read(field_offset(f), 4);
      if (&vel[30:23]) begin
        return RC_BAD_VEL;
      end
    end
    return RC_OK;
  endfunction

  // Advances the predictor by one accepted byte and queues any records it causes.
  task automatic deframe_byte(input logic [7:0] b);
    logic [2:0] code;
    field_rec_t rec;
    if (df_state == DF_HUNT) begin
      if (match_cnt < START_LEN && b == SOP_BYTES[8*(START_LEN-1-match_cnt) +: 8]) begin
        pkt_img[match_cnt] = b;
        if (match_cnt == START_LEN - 1) begin
          df_state  = DF_COLLECT;
          fill_cnt  = 7'(START_LEN);
          match_cnt = '0;
        end else begin
          match_cnt = match_cnt + 3'd1;
        end
      end else if (b == SOP_BYTES[47:40]) begin
        // A stray start byte begins a fresh match rather than being lost.
        pkt_img[0] = b;
        match_cnt  = 3'd1;
      end else begin
        match_cnt = '0;
      end
    end else begin
      pkt_img[fill_cnt] = b;
      fill_cnt = fill_cnt + 7'd1;
      if (fill_cnt == PKT_LEN) begin
        code      = packet_verdict();
        df_state  = DF_HUNT;
        fill_cnt  = '0;
        match_cnt = '0;
        if (code != RC_OK) begin
          pkts_bad++;
          rec = '{code: code, idx: 5'd0, value: 32'd0, last: 1'b1};
          expected_fields.push_back(rec);
        end else begin
          pkts_good++;
          for (int f = 0; f < NUM_FIELDS; f++) begin
            rec.code  = RC_OK;
            rec.idx   = 5'(f);
            rec.value = le_read(field_offset(f), field_bytes(f));
            rec.last  = (f == NUM_FIELDS - 1);
            expected_fields.push_back(rec);
          end
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    if (err_count < MAX_PRINTS) begin
      $display("[%0t] mismatch after %0d records: %s got %h expected %h",
               $realtime, recs_checked, what, got_v, want_v);
    end
    err_count++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_byte_queue.push_back(b);
    bytes_pushed++;
  endtask

  // Builds one complete 116-byte packet of the given kind and queues it. The ID,
  // system-type and checksum kinds also break later checks, exercising the check order.
  task automatic push_packet(input pkt_kind_t kind, input fill_t fill);
    logic [7:0]  img [0:PKT_LEN-1];
    logic [15:0] csum;
    int          p;
    for (int i = 0; i < PKT_LEN; i++) begin
      case (fill)
        FILL_ZERO: img[i] = 8'h00;
        FILL_ONES: img[i] = 8'hFF;
        default:   img[i] = 8'($urandom_range(255));
      endcase
    end
    for (int i = 0; i < START_LEN; i++) begin
      img[i] = SOP_BYTES[8*(START_LEN-1-i) +: 8];
    end
    for (int i = 0; i < ID_LEN; i++) begin
      img[START_LEN + i] = DATA_ID_BYTES[8*(ID_LEN-1-i) +: 8];
    end
    img[SYS_TYPE_POS] = SYS_TYPE_VAL;
    // Keep all velocities finite first; a top exponent bit of zero is enough.
    for (int f = 8; f <= 10; f++) begin
      p = field_offset(f);
      img[p+3][6] = 1'b0;
    end
    case (kind)
      PK_BAD_ID: begin
        img[START_LEN + $urandom_range(ID_LEN-1)] ^= 8'($urandom_range(255, 1));
        img[SYS_TYPE_POS] ^= 8'h01;
      end
      PK_BAD_SYS: begin
        img[SYS_TYPE_POS] ^= 8'($urandom_range(255, 1));
      end
      PK_BAD_SUM, PK_BAD_VX, PK_BAD_VY, PK_BAD_VZ: begin
        p = (kind == PK_BAD_VY) ? VY_POS : (kind == PK_BAD_VZ) ? VZ_POS : VX_POS;
        img[p+3][6:0] = 7'h7F;
        img[p+2][7]   = 1'b1;
      end
      default: begin
      end
    endcase
    csum = '0;
    for (int i = 0; i < SUM_END; i++) begin
      csum = csum + {8'h00, img[i]};
    end
    if (kind == PK_BAD_ID || kind == PK_BAD_SYS || kind == PK_BAD_SUM) begin
      csum = csum + 16'($urandom_range(65535, 1));
    end
    img[SUM_END]   = csum[7:0];
    img[SUM_END+1] = csum[15:8];
    for (int i = 0; i < PKT_LEN; i++) begin
      push_byte(img[i]);
    end
  endtask

  // Mostly well-formed packets with random content and random defects, mixed
  // with line noise and start patterns that break off early. Only packet bytes
  // count toward the byte target.
  task automatic push_random_traffic(input int byte_target, input int rec_target);
    int        pkt_total;
    int        rec_total;
    int        pick;
    int        n;
    pkt_kind_t kind;
    pkt_total = 0;
    rec_total = 0;
    while (pkt_total < byte_target || rec_total < rec_target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        n = $urandom_range(9);
        case (n)
          6:       kind = PK_BAD_ID;
          7:       kind = PK_BAD_SYS;
          8:       kind = PK_BAD_SUM;
          9:       kind = pkt_kind_t'(PK_BAD_VX + $urandom_range(2));
          default: kind = PK_GOOD;
        endcase
        push_packet(kind, FILL_RANDOM);
        pkt_total += PKT_LEN;
        rec_total += (kind == PK_GOOD) ? NUM_FIELDS : 1;
      end else if (pick < 85) begin
        n = $urandom_range(8, 1);
        repeat (n) push_byte(8'($urandom_range(255)));
      end else begin
        n = $urandom_range(START_LEN - 1, 1);
        for (int i = 0; i < n; i++) begin
          push_byte(SOP_BYTES[8*(START_LEN-1-i) +: 8]);
        end
        push_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // Waits until every queued byte has been taken and every expected record has
  // come out, then lets the sequencer run dry before anything else happens.
  task automatic wait_quiet();
    int waited;
    while (bytes_accepted != bytes_pushed) begin
      @(negedge clk);
    end
    waited = 0;
    while (expected_fields.size() != 0 && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_fields.size() != 0) begin
      report_mismatch("records never delivered", 32'd0, 32'(expected_fields.size()));
      expected_fields.delete();
    end
  endtask

  // Byte driver: presents the next queued byte at the falling edge and holds it
  // until the rising edge at which valid and ready were both seen high.
  always @(negedge clk) begin : byte_driver
    logic       next_valid;
    logic [7:0] next_byte;
    next_valid = byte_ch.valid;
    next_byte  = byte_ch.rx_byte;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else begin
      if (byte_ch.valid && byte_taken) begin
        next_valid = 1'b0;
      end
      if (!next_valid && rx_byte_queue.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        next_byte  = rx_byte_queue.pop_front();
        next_valid = 1'b1;
      end
    end
    byte_ch.valid   <= next_valid;
    byte_ch.rx_byte <= next_byte;
  end

  // The long hold-off is timed here, in cycles, independent of the traffic.
  always @(posedge clk) begin : stall_timer
    if (!rst_n) begin
      stall_left <= 0;
    end else if (hold_go) begin
      stall_left <= LONG_STALL;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Record sink: random back-pressure, and never ready during the long hold-off.
  always @(negedge clk) begin : record_ready
    if (!rst_n || stall_left != 0) begin
      rec_ch.ready <= 1'b0;
    end else begin
      rec_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: at each rising edge, feed an accepted byte to the predictor, then
  // compare an accepted record field by field with the oldest expectation.
  always @(posedge clk) begin : record_monitor
    field_rec_t got;
    field_rec_t want;
    cycle_count++;
    if (!rst_n) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= byte_ch.valid && byte_ch.ready;
      if (byte_ch.valid && byte_ch.ready) begin
        bytes_accepted++;
        deframe_byte(byte_ch.rx_byte);
      end
      if (rec_ch.valid && rec_ch.ready) begin
        got.code  = rec_ch.result_code;
        got.idx   = rec_ch.field_index;
        got.value = rec_ch.field_value;
        got.last  = rec_ch.last_record;
        if (expected_fields.size() == 0) begin
          report_mismatch("record with none expected", got.value, 32'd0);
        end else begin
          want = expected_fields.pop_front();
          if (got.code !== want.code) begin
            report_mismatch("result_code", 32'(got.code), 32'(want.code));
          end
          if (got.idx !== want.idx) begin
            report_mismatch("field_index", 32'(got.idx), 32'(want.idx));
          end
          if (got.value !== want.value) begin
            report_mismatch("field_value", got.value, want.value);
          end
          if (got.last !== want.last) begin
            report_mismatch("last_record", 32'(got.last), 32'(want.last));
          end
        end
        recs_checked++;
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    hold_go         = 1'b0;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = 8'h00;
    rec_ch.ready    = 1'b0;
    bytes_pushed    = 0;
    bytes_accepted  = 0;
    recs_checked    = 0;
    err_count       = 0;
    cycle_count     = 0;
    pkts_good       = 0;
    pkts_bad        = 0;
    send_idle_pct   = 6;
    recv_idle_pct   = 81;
    df_state        = DF_HUNT;
    match_cnt       = '0;
    fill_cnt        = '0;
    for (int i = 0; i < PKT_LEN; i++) begin
      pkt_img[i] = 8'h00;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. First the hunt: bytes that never match, a start pattern
    // that breaks on a non-start byte, and one that breaks on a new start byte,
    // which then runs straight into a packet that begins with another start byte.
    push_byte(8'h00);
    push_byte(8'hFF);
    for (int i = 0; i < 4; i++) begin
      push_byte(SOP_BYTES[8*(START_LEN-1-i) +: 8]);
    end
    push_byte(8'hFF);
    push_byte(8'hAA);
    push_byte(8'h10);
    push_byte(8'hAA);
    // A good packet with random payload under a slow sink.
    push_packet(PK_GOOD, FILL_RANDOM);
    wait_quiet();

    // Second phase: the sender is slow and the sink is nearly always ready.
    send_idle_pct = 81;
    recv_idle_pct = 6;
    push_random_traffic(PKT_LEN, 1);
    wait_quiet();

    // Last phase: no idling on either side, opened by a long sink hold-off while
    // a good packet streams in, so the record burst backs up into the input while
    // a packet with a random defect waits behind it.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_packet(PK_GOOD, FILL_ONES);
    push_packet(pkt_kind_t'($urandom_range(PK_BAD_VZ, PK_BAD_ID)), FILL_RANDOM);
    hold_go = 1'b1;
    @(negedge clk);
    hold_go = 1'b0;
    wait_quiet();

    $display("Drove %0d bytes: %0d packets framed, %0d passed validation, %0d rejected.",
             bytes_accepted, pkts_good + pkts_bad, pkts_good, pkts_bad);
    $display("Checked %0d field records; %0d mismatches found.", recs_checked, err_count);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
